// File: src/osq_pkg.sv
// Package with the request and result types, action codes and default sizes of the ordered table.
package osq_pkg;

  // Default storage sizes.
  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_WIDTH_DEFAULT = 32;

  // Fixed field widths of the request and result items.
  localparam int POS_W = 5;
  localparam int DATA_W = 32;

  // Operation codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_INSERT_AT     = 3'd0,
    ACT_INSERT_SORTED = 3'd1,
    ACT_ERASE_AT      = 3'd2,
    ACT_REMOVE_ALL    = 3'd3,
    ACT_GET           = 3'd4,
    ACT_SET           = 3'd5,
    ACT_FIND          = 3'd6
  } osq_action_t;

  // One request item.
  typedef struct packed {
    osq_action_t         action;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   item_value;
  } osq_req_t;

  // One result item.
  typedef struct packed {
    logic                ok;
    logic [POS_W-1:0]    result_position;
    logic [DATA_W-1:0]   read_value;
    logic [POS_W-1:0]    removed_count;
    logic [POS_W-1:0]    length_now;
  } osq_res_t;

endpackage

// File: src/osq_ram.sv
// Single-port synchronous RAM that holds the table entries.
module osq_ram
  import osq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic                   we,
  input  logic [AW-1:0]          addr,
  input  logic [VALUE_WIDTH-1:0] wdata,
  output logic [VALUE_WIDTH-1:0] rdata
);

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  // One access per cycle; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: src/osq_ctrl.sv
// Sequencer that runs each table operation as a series of RAM reads and writes.
module osq_ctrl
  import osq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  osq_req_t               request,
  output logic                   busy,
  output logic                   mem_en,
  output logic                   mem_we,
  output logic [AW-1:0]          mem_addr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  input  logic [VALUE_WIDTH-1:0] mem_rdata,
  output logic                   res_valid,
  output osq_res_t               res
);

  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_SET_WR,
    S_DOWN_RD,
    S_DOWN_WR,
    S_COMP_RD,
    S_COMP_CHK,
    S_GET_RD,
    S_GET_DATA,
    S_DONE
  } state_t;

  state_t                 state;
  osq_action_t            act;
  logic [VALUE_WIDTH-1:0] val;
  logic [CW-1:0]          count;
  logic [CW-1:0]          k;
  logic [CW-1:0]          w;
  logic [CW-1:0]          n;
  logic [CW-1:0]          tgt;
  logic [CW-1:0]          rpos;
  logic [VALUE_WIDTH-1:0] rval;
  logic                   ok;

  logic [PW-1:0]          pos_w;
  logic [PW-1:0]          cnt_w;
  logic                   full;
  logic [CW-1:0]          k_inc;
  logic [CW-1:0]          k_dec;
  logic                   not_less;
  logic [CW-1:0]          scan_hit;
  logic                   scan_stop;
  logic                   keep;
  logic [CW-1:0]          n_next;
  logic [CW-1:0]          w_next;

  // Request position and count compared at a common width.
  assign pos_w = PW'(request.position);
  assign cnt_w = PW'(count);
  assign full  = (count == CW'(DEPTH));
  assign k_inc = k + CW'(1);
  assign k_dec = k - CW'(1);

  // Sorted insert stops at the first entry not less than the value, or at the end.
  assign not_less  = !(mem_rdata < val);
  assign scan_hit  = not_less ? k : count;
  assign scan_stop = not_less || (k_inc == count);

  // Compaction keeps every entry that differs from the value.
  assign keep   = (mem_rdata != val);
  assign n_next = keep ? n : n + CW'(1);
  assign w_next = keep ? w + CW'(1) : w;

  assign busy = (state != S_IDLE);

  // Sequencer state, list count and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            act  <= request.action;
            val  <= VALUE_WIDTH'(request.item_value);
            ok   <= 1'b0;
            rpos <= '0;
            rval <= '0;
            n    <= '0;
            w    <= '0;
            k    <= '0;
            tgt  <= CW'(request.position);
            case (request.action)
              ACT_INSERT_AT: begin
                if (pos_w <= cnt_w && !full) begin
                  ok    <= 1'b1;
                  k     <= count;
                  state <= (pos_w == cnt_w) ? S_PUT : S_SHIFT_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_INSERT_SORTED: begin
                if (full) begin
                  state <= S_DONE;
                end else if (count == '0) begin
                  ok    <= 1'b1;
                  tgt   <= '0;
                  state <= S_PUT;
                end else begin
                  state <= S_SCAN_RD;
                end
              end
              ACT_ERASE_AT: begin
                if (pos_w < cnt_w) begin
                  ok <= 1'b1;
                  if (pos_w + PW'(1) == cnt_w) begin
                    count <= count - CW'(1);
                    state <= S_DONE;
                  end else begin
                    k     <= CW'(request.position) + CW'(1);
                    state <= S_DOWN_RD;
                  end
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_REMOVE_ALL: begin
                state <= (count == '0) ? S_DONE : S_COMP_RD;
              end
              ACT_GET: begin
                if (pos_w < cnt_w) begin
                  ok    <= 1'b1;
                  state <= S_GET_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_SET: begin
                if (pos_w < cnt_w) begin
                  ok    <= 1'b1;
                  state <= S_SET_WR;
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_FIND: begin
                state <= (count == '0) ? S_DONE : S_SCAN_RD;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (act == ACT_FIND) begin
            if (mem_rdata == val) begin
              ok    <= 1'b1;
              rpos  <= k;
              state <= S_DONE;
            end else if (k_inc == count) begin
              state <= S_DONE;
            end else begin
              k     <= k_inc;
              state <= S_SCAN_RD;
            end
          end else if (scan_stop) begin
            ok    <= 1'b1;
            rpos  <= scan_hit;
            tgt   <= scan_hit;
            k     <= count;
            state <= (scan_hit == count) ? S_PUT : S_SHIFT_RD;
          end else begin
            k     <= k_inc;
            state <= S_SCAN_RD;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          k     <= k_dec;
          state <= (k_dec == tgt) ? S_PUT : S_SHIFT_RD;
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_SET_WR: begin
          state <= S_DONE;
        end
        S_DOWN_RD: begin
          state <= S_DOWN_WR;
        end
        S_DOWN_WR: begin
          if (k_inc == count) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end else begin
            k     <= k_inc;
            state <= S_DOWN_RD;
          end
        end
        S_COMP_RD: begin
          state <= S_COMP_CHK;
        end
        S_COMP_CHK: begin
          n <= n_next;
          w <= w_next;
          if (k_inc == count) begin
            count <= w_next;
            ok    <= (n_next != '0);
            state <= S_DONE;
          end else begin
            k     <= k_inc;
            state <= S_COMP_RD;
          end
        end
        S_GET_RD: begin
          state <= S_GET_DATA;
        end
        S_GET_DATA: begin
          rval  <= mem_rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // RAM port driven from the current step.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = k[AW-1:0];
    mem_wdata = mem_rdata;
    case (state)
      S_SCAN_RD, S_COMP_RD, S_DOWN_RD: begin
        mem_en = 1'b1;
      end
      S_SHIFT_RD: begin
        mem_en   = 1'b1;
        mem_addr = k_dec[AW-1:0];
      end
      S_SHIFT_WR: begin
        mem_en = 1'b1;
        mem_we = 1'b1;
      end
      S_PUT, S_SET_WR: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = tgt[AW-1:0];
        mem_wdata = val;
      end
      S_DOWN_WR: begin
        mem_en   = 1'b1;
        mem_we   = 1'b1;
        mem_addr = k_dec[AW-1:0];
      end
      S_COMP_CHK: begin
        mem_en   = keep;
        mem_we   = keep;
        mem_addr = w[AW-1:0];
      end
      S_GET_RD: begin
        mem_en   = 1'b1;
        mem_addr = tgt[AW-1:0];
      end
      default: begin
        mem_en = 1'b0;
      end
    endcase
  end

  // Result fields, valid in the final step of each operation.
  assign res_valid           = (state == S_DONE);
  assign res.ok              = ok;
  assign res.result_position = POS_W'(rpos);
  assign res.read_value      = DATA_W'(rval);
  assign res.removed_count   = POS_W'(n);
  assign res.length_now      = POS_W'(count);

  // The list never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above capacity");

  // No RAM traffic while waiting for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!mem_en && !mem_we))
    else $error("RAM access while idle");

  // An accepted request always starts work.
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> (state != S_IDLE))
    else $error("accepted request did not start");

  // Remove-all reports success exactly when something was removed.
  a_remove_ok: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && act == ACT_REMOVE_ALL) |-> (ok == (n != '0)))
    else $error("remove-all status disagrees with removed count");

endmodule

// File: src/ordered_sequence_table_top.sv
// Top level of the ordered table: sequencer, entry RAM and result register.
//
// The single RAM port does one read or one write per cycle, and moving one
// entry costs a read and a write, so insert_at, insert_sorted and erase_at take
// longer the more entries they move, and remove_all and find the more entries
// they scan. busy is high from the cycle after start is taken until the cycle
// in which done rises, so a new request may be issued in the same cycle as the
// previous result. Each result is shown for exactly one cycle with done high;
// the receiver must take it then. Stored entries are not cleared at reset and
// need no clearing pass.
module ordered_sequence_table_top
  import osq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  osq_req_t request,
  output logic     busy,
  output logic     done,
  output osq_res_t result
);

  localparam int AW = $clog2(DEPTH);

  logic                   mem_en;
  logic                   mem_we;
  logic [AW-1:0]          mem_addr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   res_valid;
  osq_res_t               res;

  osq_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res)
  );

  osq_ram #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Output register: one-cycle strobe with the result item.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
    end
    if (res_valid) begin
      result <= res;
    end
  end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the ordered sequence table: directed table, then random phases.
module tb;
  import osq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
  localparam logic [DATA_W-1:0] VAL_MASK =
    (VALUE_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << VALUE_WIDTH) - DATA_W'(1));
  // Action code with no operation behind it.
  localparam logic [2:0] ACT_SPARE = 3'd7;
  // Drain time after the last result, sized from DEPTH to cover the longest request.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 60;

  typedef enum {GROW, MIXED, SHRINK} mix_t;

  // One row of the directed table; pinned rows carry a hand-written result.
  typedef struct {
    osq_req_t req;
    bit       pinned;
    osq_res_t res;
  } dir_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  osq_req_t request = '0;
  logic     busy;
  logic     done;
  osq_res_t result;

  // Shadow copy of the list contents and its length.
  logic [DATA_W-1:0] list_vals [DEPTH];
  int                list_len = 0;

  osq_res_t awaited_results [$];
  int       mismatch_count = 0;
  int       checked_count = 0;
  int       act_seen [8];
  int       full_hits = 0;
  int       empty_hits = 0;

  // Directed rows: empty-list failures, extremes of position and value, every action.
  dir_row_t dir_rows [20] = '{
    '{'{ACT_GET,           5'd0,  32'h0000_0000}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd0}},
    '{'{ACT_ERASE_AT,      5'd0,  32'h0000_0000}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd0}},
    '{'{ACT_FIND,          5'd0,  32'hFFFF_FFFF}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd0}},
    '{'{ACT_REMOVE_ALL,    5'd0,  32'h0000_0000}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd0}},
    '{'{ACT_INSERT_AT,     5'd1,  32'h0000_0005}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd0}},
    '{'{ACT_INSERT_AT,     5'd0,  32'hFFFF_FFFF}, 1'b1, '{1'b1, 5'd0, 32'h0, 5'd0, 5'd1}},
    '{'{ACT_INSERT_SORTED, 5'd0,  32'h0000_0000}, 1'b1, '{1'b1, 5'd0, 32'h0, 5'd0, 5'd2}},
    '{'{ACT_INSERT_SORTED, 5'd31, 32'h8000_0000}, 1'b1, '{1'b1, 5'd1, 32'h0, 5'd0, 5'd3}},
    '{'{ACT_GET,           5'd2,  32'h0000_0000}, 1'b1,
      '{1'b1, 5'd0, 32'hFFFF_FFFF, 5'd0, 5'd3}},
    '{'{ACT_SET,           5'd31, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd3}},
    '{'{ACT_SET,           5'd0,  32'h8000_0000}, 1'b0, '0},
    '{'{ACT_FIND,          5'd0,  32'h8000_0000}, 1'b0, '0},
    '{'{ACT_INSERT_AT,     5'd3,  32'h0000_0000}, 1'b0, '0},
    '{'{ACT_INSERT_SORTED, 5'd0,  32'h7FFF_FFFF}, 1'b0, '0},
    '{'{ACT_REMOVE_ALL,    5'd0,  32'h8000_0000}, 1'b0, '0},
    '{'{osq_action_t'(ACT_SPARE), 5'd31, 32'hFFFF_FFFF}, 1'b1,
      '{1'b0, 5'd0, 32'h0, 5'd0, 5'd3}},
    '{'{ACT_ERASE_AT,      5'd3,  32'h0000_0000}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd3}},
    '{'{ACT_ERASE_AT,      5'd0,  32'h0000_0000}, 1'b0, '0},
    '{'{ACT_GET,           5'd16, 32'h0000_0000}, 1'b1, '{1'b0, 5'd0, 32'h0, 5'd0, 5'd2}},
    '{'{ACT_FIND,          5'd0,  32'h0000_0000}, 1'b0, '0}
  };

  ordered_sequence_table_top #(
    .DEPTH(DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Opens a slot at the given index, moving later entries up.
  function automatic void open_slot(int at, logic [DATA_W-1:0] v);
    for (int k = list_len; k > at; k--) begin
      list_vals[k] = list_vals[k-1];
    end
    list_vals[at] = v;
    list_len++;
  endfunction

  // Applies one request to the shadow list and returns the result it should give.
  function automatic osq_res_t apply_request(osq_req_t req);
    osq_res_t          r;
    logic [DATA_W-1:0] v;
    int                p;
    int                k;
    int                w;
    int                n;
    r = '0;
    v = req.item_value & VAL_MASK;
    p = int'(req.position);
    case (req.action)
      ACT_INSERT_AT: begin
        if (p <= list_len && list_len < DEPTH) begin
          open_slot(p, v);
          r.ok = 1'b1;
        end
      end
      ACT_INSERT_SORTED: begin
        if (list_len < DEPTH) begin
          k = 0;
          while (k < list_len && list_vals[k] < v) k++;
          open_slot(k, v);
          r.ok = 1'b1;
          r.result_position = POS_W'(k);
        end
      end
      ACT_ERASE_AT: begin
        if (p < list_len) begin
          for (k = p; k + 1 < list_len; k++) begin
            list_vals[k] = list_vals[k+1];
          end
          list_len--;
          r.ok = 1'b1;
        end
      end
      ACT_REMOVE_ALL: begin
        w = 0;
        n = 0;
        for (k = 0; k < list_len; k++) begin
          if (list_vals[k] == v) begin
            n++;
          end else begin
            list_vals[w] = list_vals[k];
            w++;
          end
        end
        list_len = w;
        r.removed_count = POS_W'(n);
        r.ok = (n > 0);
      end
      ACT_GET: begin
        if (p < list_len) begin
          r.read_value = list_vals[p];
          r.ok = 1'b1;
        end
      end
      ACT_SET: begin
        if (p < list_len) begin
          list_vals[p] = v;
          r.ok = 1'b1;
        end
      end
      ACT_FIND: begin
        for (k = 0; k < list_len; k++) begin
          if (list_vals[k] == v) begin
            r.ok = 1'b1;
            r.result_position = POS_W'(k);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    r.length_now = POS_W'(list_len);
    return r;
  endfunction

  // Chooses an action; growing phases favor inserts, shrinking phases favor removal.
  function automatic osq_action_t pick_action(mix_t mode);
    int wt [8];
    int roll;
    case (mode)
      GROW:    wt = '{30, 30, 6, 4, 10, 10, 9, 1};
      SHRINK:  wt = '{6, 6, 34, 24, 10, 10, 9, 1};
      default: wt = '{14, 14, 14, 12, 14, 14, 14, 4};
    endcase
    roll = $urandom_range(0, 99);
    for (int k = 0; k < 8; k++) begin
      if (roll < wt[k]) return osq_action_t'(k[2:0]);
      roll -= wt[k];
    end
    return ACT_FIND;
  endfunction

  // Values come mostly from a small pool so that duplicates and matches are common.
  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(0, 9) > 5) return DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0000_0001;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5:       return 32'h0000_0005;
      6:       return 32'h0000_1000;
      default: return 32'hDEAD_BEEF;
    endcase
  endfunction

  // Presents one item and holds it until the block takes it, then records the result it should give.
  task automatic issue(input osq_req_t req, input bit pinned, input osq_res_t pinned_res);
    osq_res_t predicted;
    start <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    act_seen[req.action]++;
    if (list_len == 0) empty_hits++;
    if (list_len == DEPTH &&
        (req.action == ACT_INSERT_AT || req.action == ACT_INSERT_SORTED)) full_hits++;
    predicted = apply_request(req);
    awaited_results.push_back(pinned ? pinned_res : predicted);
  endtask

  // Random gap between items: mostly none or short, now and then long.
  task automatic rest(input bit quiet);
    int roll;
    int n;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) n = 0;
    else if (roll < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Result checker: each strobe is compared with the oldest awaited result.
  always @(posedge clk) begin
    osq_res_t want;
    if (!rst && done) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Result with nothing awaited: ok=%0b pos=%0d val=%h cnt=%0d len=%0d",
                   result.ok, result.result_position, result.read_value,
                   result.removed_count, result.length_now);
      end else begin
        want = awaited_results.pop_front();
        checked_count++;
        if (result.ok !== want.ok || result.result_position !== want.result_position ||
            result.read_value !== want.read_value ||
            result.removed_count !== want.removed_count ||
            result.length_now !== want.length_now) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected ok=%0b pos=%0d val=%h cnt=%0d len=%0d, got ok=%0b pos=%0d val=%h cnt=%0d len=%0d",
                     want.ok, want.result_position, want.read_value,
                     want.removed_count, want.length_now,
                     result.ok, result.result_position, result.read_value,
                     result.removed_count, result.length_now);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    osq_req_t req;
    mix_t     mode;
    bit       quiet;
    foreach (act_seen[i]) act_seen[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      issue(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].res);
      rest(1'b0);
    end

    // Phases rotate between filling, mixing and draining the list.
    for (int ph = 0; ph < PHASES; ph++) begin
      mode = mix_t'(ph % 3);
      quiet = (ph % 4 == 1);
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        req.action = pick_action(mode);
        if ($urandom_range(0, 99) < 85) req.position = POS_W'($urandom_range(0, list_len));
        else req.position = POS_W'($urandom_range(0, 31));
        req.item_value = pick_value();
        issue(req, 1'b0, '0);
        rest(quiet);
      end
    end
    start <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests: insert_at %0d, insert_sorted %0d, erase_at %0d, remove_all %0d, get %0d, set %0d, find %0d, unused code %0d.",
             act_seen.sum(), act_seen[ACT_INSERT_AT], act_seen[ACT_INSERT_SORTED],
             act_seen[ACT_ERASE_AT], act_seen[ACT_REMOVE_ALL], act_seen[ACT_GET],
             act_seen[ACT_SET], act_seen[ACT_FIND], act_seen[ACT_SPARE]);
    $display("Inserts met a full list %0d times, requests met an empty list %0d times; %0d results checked, %0d mismatches.",
             full_hits, empty_hits, checked_count, mismatch_count);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
